@@ hw/rtl/histogram_threshold_selector_assert.svh @@
// Assertion macros shared by the histogram threshold selector RTL.
`ifndef HISTOGRAM_THRESHOLD_SELECTOR_ASSERT_SVH
`define HISTOGRAM_THRESHOLD_SELECTOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/hts_pkg.sv @@
// Types and constants of the histogram threshold selector.
`default_nettype none
package hts_pkg;
  localparam int BINS          = 256;
  localparam int COUNT_BITS    = 24;
  localparam int IDX_BITS      = $clog2(BINS);
  localparam int NCNT_BITS     = IDX_BITS + 1;
  localparam int TOTAL_BITS    = 32;
  localparam int ACC_BITS      = 32;
  localparam int SUM_BITS      = ACC_BITS + IDX_BITS;
  localparam int PROD_BITS     = 2 * ACC_BITS;
  localparam int AUX_BITS      = 2 * IDX_BITS;
  localparam int SCORE_BITS    = AUX_BITS + COUNT_BITS + 3;
  localparam int THR_BITS      = 10;
  localparam int STATUS_BITS   = 2;
  localparam int QFRAC_BITS    = 16;
  localparam int ITER_BITS     = 8;
  localparam int METHOD_BITS   = 2;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam int DIV_STEP_BITS = $clog2(SUM_BITS + 1);

  localparam logic [NCNT_BITS-1:0] BINS_N = NCNT_BITS'(BINS);

  typedef enum logic [METHOD_BITS-1:0] {
    METH_MEAN,
    METH_QUANTILE,
    METH_TWO_PEAKS,
    METH_ITERATIVE
  } method_t;

  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_CAP   = 2'd2;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_METHOD = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_QFRAC  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAXIT  = 2'd2;

  localparam logic [QFRAC_BITS-1:0] QFRAC_RESET = 16'h8000;
  localparam logic [ITER_BITS-1:0]  MAXIT_RESET = 8'd64;

  typedef struct packed {
    logic [COUNT_BITS-1:0] bin_count;
    logic                  last_bin;
  } in_item_t;

  typedef struct packed {
    logic signed [THR_BITS-1:0] threshold;
    logic [STATUS_BITS-1:0]     status;
  } out_item_t;

  typedef struct packed {
    logic                start;
    logic [SUM_BITS-1:0] num;
    logic [ACC_BITS-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [SUM_BITS-1:0] quo;
    logic [ACC_BITS-1:0] rem;
  } div_resp_t;
endpackage
`default_nettype wire

@@ hw/rtl/hts_ram.sv @@
// Generic single-clock RAM, one write port, one registered read port.
`default_nettype none
module hts_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ hw/rtl/hts_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module hts_div (
  input  logic               clk,
  input  logic               rst,
  input  hts_pkg::div_req_t  req,
  output hts_pkg::div_resp_t resp
);
  import hts_pkg::*;

  logic                     busy;
  logic                     done;
  logic [DIV_STEP_BITS-1:0] step;
  logic [SUM_BITS-1:0]      quo;
  logic [ACC_BITS-1:0]      rem;
  logic [ACC_BITS-1:0]      den;
  logic [ACC_BITS:0]        trial;
  logic [ACC_BITS:0]        diff;
  logic                     fits;

  // partial remainder with the next dividend bit shifted in
  assign trial = {rem, quo[SUM_BITS-1]};
  assign fits  = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && !req.start && (step == DIV_STEP_BITS'(SUM_BITS - 1));
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
        quo  <= req.num;
        rem  <= '0;
        den  <= req.den;
      end else if (busy) begin
        quo  <= {quo[SUM_BITS-2:0], fits};
        rem  <= fits ? diff[ACC_BITS-1:0] : trial[ACC_BITS-1:0];
        step <= step + 1'b1;
        if (step == DIV_STEP_BITS'(SUM_BITS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign resp.done = done;
  assign resp.quo  = quo;
  assign resp.rem  = rem;
endmodule
`default_nettype wire

@@ hw/rtl/histogram_threshold_selector.sv @@
// Top level: histogram bin store, threshold search sequencer and result register.
//
// Usage: bins stream in on in_valid/in_ready, one bin_count per transaction,
// lowest gray level first; last_bin closes the histogram. Bins load at one per
// cycle into a 256 x 24 RAM. After the last bin in_ready drops and the
// sequencer walks the RAM through its single read port, one bin per cycle.
// Steps from the last bin to out_valid:
//   mean:        one sweep, then a 40-step serial divide
//   quantile:    a multiply, then one sweep
//   two peaks:   two full sweeps, then a sweep from peak to peak inclusive
//   iterative:   mean as start value; per pass a sweep, two divides, two multiplies
// The divider is bit-serial, 40 steps per divide. An empty histogram answers
// with threshold -1 and status 1. The result sits in an output register until
// out_ready; a stalled receiver holds the block only when the next result is
// ready, and loading of the next histogram proceeds meanwhile. Configuration
// writes on cfg_we take effect at once and are meant for idle periods.
// Reset (rst, synchronous) clears the bin counter, total and sequencer; the
// RAM content is not cleared since only bins written for the current
// histogram are ever read.
`default_nettype none
`include "histogram_threshold_selector_assert.svh"
module histogram_threshold_selector (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  hts_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output hts_pkg::out_item_t                   out_data,
  input  logic                                 cfg_we,
  input  logic [hts_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [hts_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import hts_pkg::*;

  typedef enum logic [4:0] {
    S_LOAD, S_START, S_SUM, S_DIV_MEAN_GO, S_DIV_MEAN,
    S_QMUL, S_QSCAN,
    S_PEAK1, S_P1_DONE, S_PEAK2, S_P2_DONE, S_VALLEY, S_V_DONE,
    S_ITER, S_DIV_HI_GO, S_DIV_HI, S_DIV_LO_GO, S_DIV_LO,
    S_MUL_HI, S_MUL_LO, S_DECIDE, S_RESULT
  } state_t;

  state_t state;

  // configuration
  method_t               method;
  logic [QFRAC_BITS-1:0] qfrac;
  logic [ITER_BITS-1:0]  max_it;

  // loading
  logic [NCNT_BITS-1:0]  bins_loaded;
  logic [TOTAL_BITS-1:0] total;
  logic [TOTAL_BITS:0]   total_sum;
  logic [TOTAL_BITS-1:0] total_next;
  logic                  in_acc;
  logic                  ram_we;
  logic [NCNT_BITS-1:0]  n_r;
  logic [TOTAL_BITS-1:0] tot_r;

  // sweep engine
  logic [IDX_BITS-1:0]   sw_addr;
  logic [IDX_BITS-1:0]   sw_end;
  logic                  issuing;
  logic                  rd_vld;
  logic                  rd_last;
  logic [IDX_BITS-1:0]   rd_idx;
  logic [AUX_BITS-1:0]   aux;
  logic [AUX_BITS-1:0]   aux_d;
  logic [IDX_BITS-1:0]   pk_dist;
  logic [COUNT_BITS-1:0] cnt;
  logic                  sweeping;

  // per-method working registers
  logic [SUM_BITS-1:0]          acc_s;
  logic [ACC_BITS:0]            cum;
  logic [ACC_BITS:0]            cum_next;
  logic                         q_hit;
  logic                         found;
  logic [IDX_BITS-1:0]          qres;
  logic signed [SCORE_BITS-1:0] best;
  logic signed [SCORE_BITS-1:0] score;
  logic [AUX_BITS+COUNT_BITS-1:0] pk2_prod;
  logic signed [COUNT_BITS+1:0] vdiff;
  logic [COUNT_BITS+IDX_BITS-1:0] wprod;
  logic [IDX_BITS-1:0]   i0, i1, p1, pl, ph, mid;
  logic [IDX_BITS:0]     pair_sum;
  logic [IDX_BITS-1:0]   p2;
  logic [IDX_BITS-1:0]   tr;
  logic [ITER_BITS-1:0]  k;
  logic [ITER_BITS-1:0]  cap;
  logic [ACC_BITS-1:0]   nb, no;
  logic [SUM_BITS-1:0]   sb, so;
  logic [ACC_BITS-1:0]   no_cl, nb_cl;
  logic [IDX_BITS-1:0]   qa, qc;
  logic [ACC_BITS-1:0]   ra, rc;
  logic [PROD_BITS-1:0]  prod_a, prod_c;
  logic [IDX_BITS:0]     s_sum;
  logic [IDX_BITS-1:0]   tn;
  logic [ACC_BITS-1:0]   mul_x, mul_y;
  logic [PROD_BITS-1:0]  mul_p;
  out_item_t             res;

  div_req_t  div_req;
  div_resp_t div_resp;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      method <= METH_MEAN;
      qfrac  <= QFRAC_RESET;
      max_it <= MAXIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_METHOD: method <= method_t'(cfg_data[METHOD_BITS-1:0]);
        CFG_QFRAC:  qfrac  <= cfg_data[QFRAC_BITS-1:0];
        CFG_MAXIT:  max_it <= cfg_data[ITER_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- load path ----------------
  assign in_ready   = (state == S_LOAD);
  assign in_acc     = in_valid && in_ready;
  assign ram_we     = in_acc && (bins_loaded < BINS_N);
  assign total_sum  = {1'b0, total} + (TOTAL_BITS + 1)'(in_data.bin_count);
  assign total_next = total_sum[TOTAL_BITS] ? '1 : total_sum[TOTAL_BITS-1:0];

  hts_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (bins_loaded[IDX_BITS-1:0]),
    .wdata (in_data.bin_count),
    .raddr (sw_addr),
    .rdata (cnt)
  );

  hts_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .resp (div_resp)
  );

  // ---------------- sweep datapath ----------------
  assign sweeping = (state == S_SUM) || (state == S_QSCAN) || (state == S_PEAK1) ||
                    (state == S_PEAK2) || (state == S_VALLEY) || (state == S_ITER);

  // distance weight for the second peak, span weight for the valley
  assign pk_dist = (sw_addr >= p1) ? (sw_addr - p1) : (p1 - sw_addr);
  always_comb begin
    if (state == S_VALLEY) begin
      aux = AUX_BITS'(sw_addr - pl) * AUX_BITS'(ph - sw_addr);
    end else begin
      aux = AUX_BITS'(pk_dist) * AUX_BITS'(pk_dist);
    end
  end

  assign wprod    = (COUNT_BITS + IDX_BITS)'(cnt) * (COUNT_BITS + IDX_BITS)'(rd_idx);
  assign pk2_prod = (AUX_BITS + COUNT_BITS)'(aux_d) * (AUX_BITS + COUNT_BITS)'(cnt);
  assign vdiff    = $signed((COUNT_BITS + 2)'(mid)) - $signed((COUNT_BITS + 2)'(cnt));

  always_comb begin
    case (state)
      S_PEAK2:  score = $signed(SCORE_BITS'(pk2_prod));
      S_VALLEY: score = $signed({1'b0, aux_d}) * vdiff;
      default:  score = $signed(SCORE_BITS'(cnt));
    endcase
  end

  assign cum_next = cum + (ACC_BITS + 1)'(cnt);
  assign q_hit    = (PROD_BITS'(cum_next) << QFRAC_BITS) > prod_a;

  assign pair_sum = {1'b0, i0} + {1'b0, i1};
  assign p2       = pair_sum[IDX_BITS:1];

  // iterative selection: rounding of the averaged class means
  assign no_cl = (no == '0) ? ACC_BITS'(1) : no;
  assign nb_cl = (nb == '0) ? ACC_BITS'(1) : nb;
  assign cap   = (max_it == '0) ? ITER_BITS'(1) : max_it;
  assign s_sum = {1'b0, qa} + {1'b0, qc};
  assign tn    = s_sum[IDX_BITS:1] + IDX_BITS'(s_sum[0] && (prod_a >= prod_c));

  always_comb begin
    case (state)
      S_QMUL: begin
        mul_x = ACC_BITS'(qfrac);
        mul_y = ACC_BITS'(tot_r);
      end
      S_MUL_HI: begin
        mul_x = ra;
        mul_y = nb;
      end
      S_MUL_LO: begin
        mul_x = nb - rc;
        mul_y = no;
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end
  assign mul_p = PROD_BITS'(mul_x) * PROD_BITS'(mul_y);

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = acc_s;
    div_req.den   = ACC_BITS'(tot_r);
    case (state)
      S_DIV_MEAN_GO: div_req.start = 1'b1;
      S_DIV_HI_GO: begin
        div_req.start = 1'b1;
        div_req.num   = so;
        div_req.den   = no_cl;
      end
      S_DIV_LO_GO: begin
        div_req.start = 1'b1;
        div_req.num   = sb;
        div_req.den   = nb;
      end
      default: ;
    endcase
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_LOAD;
      bins_loaded <= '0;
      total       <= '0;
      issuing     <= 1'b0;
      rd_vld      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_RESULT)) begin
        out_valid <= 1'b0;
      end

      // read issue: address goes to the RAM, data comes back next cycle
      rd_vld <= sweeping && issuing;
      if (sweeping && issuing) begin
        rd_idx  <= sw_addr;
        rd_last <= (sw_addr == sw_end);
        aux_d   <= aux;
        sw_addr <= sw_addr + 1'b1;
        if (sw_addr == sw_end) begin
          issuing <= 1'b0;
        end
      end

      case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (in_data.last_bin) begin
              n_r         <= ram_we ? bins_loaded + 1'b1 : bins_loaded;
              tot_r       <= ram_we ? total_next : total;
              bins_loaded <= '0;
              total       <= '0;
              state       <= S_START;
            end else if (ram_we) begin
              bins_loaded <= bins_loaded + 1'b1;
              total       <= total_next;
            end
          end
        end

        S_START: begin
          sw_addr <= '0;
          sw_end  <= IDX_BITS'(n_r - 1'b1);
          if (tot_r == '0) begin
            res.threshold <= '1;
            res.status    <= ST_EMPTY;
            state         <= S_RESULT;
          end else begin
            case (method)
              METH_QUANTILE: state <= S_QMUL;
              METH_TWO_PEAKS: begin
                best    <= '0;
                i0      <= '0;
                i1      <= '0;
                issuing <= 1'b1;
                state   <= S_PEAK1;
              end
              default: begin
                acc_s   <= '0;
                issuing <= 1'b1;
                state   <= S_SUM;
              end
            endcase
          end
        end

        S_SUM: begin
          if (rd_vld) begin
            acc_s <= acc_s + SUM_BITS'(wprod);
            if (rd_last) begin
              state <= S_DIV_MEAN_GO;
            end
          end
        end

        S_DIV_MEAN_GO: state <= S_DIV_MEAN;

        S_DIV_MEAN: begin
          if (div_resp.done) begin
            if (method == METH_ITERATIVE) begin
              tr      <= div_resp.quo[IDX_BITS-1:0];
              k       <= '0;
              nb      <= '0;
              no      <= '0;
              sb      <= '0;
              so      <= '0;
              sw_addr <= '0;
              issuing <= 1'b1;
              state   <= S_ITER;
            end else begin
              res.threshold <= THR_BITS'(div_resp.quo[IDX_BITS-1:0]);
              res.status    <= ST_OK;
              state         <= S_RESULT;
            end
          end
        end

        S_QMUL: begin
          prod_a  <= mul_p;
          cum     <= '0;
          found   <= 1'b0;
          issuing <= 1'b1;
          state   <= S_QSCAN;
        end

        S_QSCAN: begin
          if (rd_vld) begin
            cum <= cum_next;
            if (!found && q_hit) begin
              found <= 1'b1;
              qres  <= rd_idx;
            end
            if (rd_last) begin
              res.status <= ST_OK;
              if (found) begin
                res.threshold <= THR_BITS'(qres);
              end else if (q_hit) begin
                res.threshold <= THR_BITS'(rd_idx);
              end else begin
                res.threshold <= THR_BITS'(n_r);
              end
              state <= S_RESULT;
            end
          end
        end

        S_PEAK1, S_PEAK2, S_VALLEY: begin
          if (rd_vld) begin
            if ((state == S_VALLEY) && (rd_idx == pl)) begin
              // valley search starts with the height of the lower-indexed peak as its best
              best <= $signed(SCORE_BITS'(cnt));
              i0   <= pl;
              i1   <= pl;
            end else if (best < score) begin
              best <= score;
              i0   <= rd_idx;
              i1   <= rd_idx;
            end else if (best == score) begin
              i1 <= rd_idx;
            end
            if (rd_last) begin
              case (state)
                S_PEAK1: state <= S_P1_DONE;
                S_PEAK2: state <= S_P2_DONE;
                default: state <= S_V_DONE;
              endcase
            end
          end
        end

        S_P1_DONE: begin
          p1      <= p2;
          best    <= '0;
          sw_addr <= '0;
          issuing <= 1'b1;
          state   <= S_PEAK2;
        end

        S_P2_DONE: begin
          if (p1 > p2) begin
            pl      <= p2;
            ph      <= p1;
            sw_addr <= p2;
            sw_end  <= p1;
          end else begin
            pl      <= p1;
            ph      <= p2;
            sw_addr <= p1;
            sw_end  <= p2;
          end
          mid     <= IDX_BITS'(({1'b0, p1} + {1'b0, p2}) >> 1);
          issuing <= 1'b1;
          state   <= S_VALLEY;
        end

        S_V_DONE: begin
          res.threshold <= THR_BITS'(p2);
          res.status    <= ST_OK;
          state         <= S_RESULT;
        end

        S_ITER: begin
          if (rd_vld) begin
            if (rd_idx <= tr) begin
              nb <= nb + ACC_BITS'(cnt);
              sb <= sb + SUM_BITS'(wprod);
            end else begin
              no <= no + ACC_BITS'(cnt);
              so <= so + SUM_BITS'(wprod);
            end
            if (rd_last) begin
              state <= S_DIV_HI_GO;
            end
          end
        end

        S_DIV_HI_GO: begin
          no    <= no_cl;
          nb    <= nb_cl;
          state <= S_DIV_HI;
        end

        S_DIV_HI: begin
          if (div_resp.done) begin
            qa    <= div_resp.quo[IDX_BITS-1:0];
            ra    <= div_resp.rem;
            state <= S_DIV_LO_GO;
          end
        end

        S_DIV_LO_GO: state <= S_DIV_LO;

        S_DIV_LO: begin
          if (div_resp.done) begin
            qc    <= div_resp.quo[IDX_BITS-1:0];
            rc    <= div_resp.rem;
            state <= S_MUL_HI;
          end
        end

        S_MUL_HI: begin
          prod_a <= mul_p;
          state  <= S_MUL_LO;
        end

        S_MUL_LO: begin
          prod_c <= mul_p;
          state  <= S_DECIDE;
        end

        S_DECIDE: begin
          if (tn == tr) begin
            res.threshold <= THR_BITS'(tr);
            res.status    <= ST_OK;
            state         <= S_RESULT;
          end else if (k + 1'b1 == cap) begin
            res.threshold <= THR_BITS'(tn);
            res.status    <= ST_CAP;
            state         <= S_RESULT;
          end else begin
            tr      <= tn;
            k       <= k + 1'b1;
            nb      <= '0;
            no      <= '0;
            sb      <= '0;
            so      <= '0;
            sw_addr <= '0;
            issuing <= 1'b1;
            state   <= S_ITER;
          end
        end

        S_RESULT: begin
          if (!out_valid || out_ready) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= S_LOAD;
          end
        end

        default: state <= S_LOAD;
      endcase
    end
  end

  // ---------------- checks ----------------
  `HTS_ASSERT_NEXT(a_last_stops_input, in_acc && in_data.last_bin, !in_ready, "input after last bin")
  `HTS_ASSERT_NOW(a_empty_marks_thr, out_valid && out_data.status == ST_EMPTY, out_data.threshold == '1, "empty result without -1")
  `HTS_ASSERT_NOW(a_loaded_bound, 1'b1, bins_loaded <= BINS_N, "bin counter beyond store depth")
  `HTS_ASSERT_NOW(a_valley_span, state == S_VALLEY && rd_vld, rd_idx >= pl && rd_idx <= ph, "valley read outside peak span")
endmodule
`default_nettype wire
